// ===== hw/rtl/can_rx_acceptance_filter_macros.svh =====
// Assertion macros used by the acceptance filter checker.
`ifndef CAN_RX_ACCEPTANCE_FILTER_MACROS_SVH
`define CAN_RX_ACCEPTANCE_FILTER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define CRAF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define CRAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/canrxaf_pkg.sv =====
// Types and constants shared by the acceptance filter modules.
package canrxaf_pkg;

  localparam int ID_W     = 11;
  localparam int KEY_W    = 12;
  localparam int IDX_IN_W = 4;
  localparam int HIT_W    = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [KEY_W-1:0] IDENT_RESET = 12'h000;
  localparam logic [KEY_W-1:0] MASK_RESET  = 12'hFFF;

  // Item kinds
  localparam logic KIND_PROGRAM = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  // Register index (paddr bit 2 and up)
  localparam logic REG_NORMAL_MODE = 1'b0;

  typedef struct packed {
    logic            kind;
    logic [3:0]      entry_index;
    logic [ID_W-1:0] filter_id;
    logic [ID_W-1:0] filter_mask;
    logic            filter_rtr;
    logic            has_receiver;
    logic [ID_W-1:0] frame_id;
    logic            frame_rtr;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic             delivered;
    logic [HIT_W-1:0] hit_entry;
    logic             rejected;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic prog;
    logic scan;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic all_seen;
  } dp_sts_t;

endpackage

// ===== hw/rtl/canrxaf_dp.sv =====
// Datapath: filter entry memory, scan read pipe, compare and result registers.
module canrxaf_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  canrxaf_pkg::ctrl_cmd_t cmd_i,
  output canrxaf_pkg::dp_sts_t   sts_o,
  input  canrxaf_pkg::in_item_t  in_item_i,
  output canrxaf_pkg::out_item_t out_item_o
);
  import canrxaf_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [KEY_W-1:0] ident;
    logic [KEY_W-1:0] mask;
  } entry_t;

  entry_t                     mem [ENTRIES];
  logic [ENTRIES-1:0]         valid_q;
  in_item_t                   item_q;
  logic [CNT_W-1:0]           iss_q;
  logic                       rd_pend_q;
  entry_t                     rd_ent_q;
  logic                       rd_vld_q;
  logic [IDX_W-1:0]           rd_idx_q;
  out_item_t                  wrk_q;
  out_item_t                  out_q;

  logic                       prog_ok;
  logic [IDX_W+IDX_IN_W-1:0]  widx_ext;
  logic [IDX_W-1:0]           waddr;
  logic [IDX_W-1:0]           raddr;
  entry_t                     wr_ent;
  logic                       rd_en;
  logic [KEY_W-1:0]           key;
  logic [KEY_W-1:0]           eff_ident;
  logic [KEY_W-1:0]           eff_mask;
  logic                       hit;
  logic [IDX_W+HIT_W-1:0]     hit_ext;

  assign prog_ok  = item_q.has_receiver && (32'(item_q.entry_index) < ENTRIES);
  assign widx_ext = {IDX_W'(0), item_q.entry_index};
  assign waddr    = widx_ext[IDX_W-1:0];
  assign raddr    = iss_q[IDX_W-1:0];
  assign wr_ent   = '{ident: {item_q.filter_rtr, item_q.filter_id},
                      mask:  {1'b1, item_q.filter_mask}};
  assign rd_en    = cmd_i.scan && (iss_q != CNT_W'(ENTRIES));

  // Unprogrammed entries read as the reset pattern.
  assign key       = {item_q.frame_rtr, item_q.frame_id};
  assign eff_ident = rd_vld_q ? rd_ent_q.ident : IDENT_RESET;
  assign eff_mask  = rd_vld_q ? rd_ent_q.mask : MASK_RESET;
  assign hit       = rd_pend_q && (((key ^ eff_ident) & eff_mask) == '0);
  assign hit_ext   = {HIT_W'(0), rd_idx_q};

  assign sts_o.hit      = hit;
  assign sts_o.all_seen = (iss_q == CNT_W'(ENTRIES)) && rd_pend_q;
  assign out_item_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prog && prog_ok) begin
      mem[waddr] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent_q <= mem[raddr];
      rd_vld_q <= valid_q[raddr];
      rd_idx_q <= raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      iss_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (cmd_i.prog && prog_ok) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.accept) begin
        iss_q     <= '0;
        rd_pend_q <= 1'b0;
      end else begin
        rd_pend_q <= rd_en;
        if (rd_en) begin
          iss_q <= iss_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_item_i;
      wrk_q  <= '0;
    end else if (cmd_i.prog) begin
      wrk_q.rejected <= !prog_ok;
    end else if (cmd_i.scan && hit) begin
      wrk_q.matched   <= 1'b1;
      wrk_q.delivered <= rd_vld_q;
      wrk_q.hit_entry <= hit_ext[HIT_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= wrk_q;
    end
  end

endmodule

// ===== hw/rtl/canrxaf_ctrl.sv =====
// Controller: sequences accept, program, scan and result hand-off.
module canrxaf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   item_kind_i,
  input  logic                   normal_mode_i,
  input  logic                   out_ready_i,
  input  canrxaf_pkg::dp_sts_t   sts_i,
  output canrxaf_pkg::ctrl_cmd_t cmd_o,
  output logic                   in_ready_o,
  output logic                   out_valid_o
);
  import canrxaf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PROG = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (item_kind_i == KIND_PROGRAM) begin
            state_d = ST_PROG;
          end else if (normal_mode_i) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_PROG: begin
        cmd_o.prog = 1'b1;
        state_d    = ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.all_seen) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/can_rx_acceptance_filter.sv =====
// Top level of the CAN receive acceptance filter bank.
//
//   Channel   Direction  Handshake              Beat
//   in        input      in_valid_i/in_ready_o  in_item_i (program or frame)
//   out       output     out_valid_o/out_ready_i out_item_o (one per input beat)
//   config    APB        psel/penable/pready    normal_mode at byte address 0
//
// One input beat is worked on at a time. A program beat goes from accept
// through the program state to its result, a frame outside normal mode goes
// straight to its result, and a frame in normal mode scans to the first hit
// or the last entry: the scan reads one filter entry per cycle from the entry
// memory through a registered read port and compares it in the next cycle.
// Reset clears the valid bits, so every entry reads as identifier 0, full
// mask, and normal_mode clears to 0; no clearing pass is needed.
// A waiting result sits in the output register; the next beat is accepted and
// worked on meanwhile, and only its hand-off stalls until out_ready_i.
module can_rx_acceptance_filter #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  canrxaf_pkg::in_item_t           in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output canrxaf_pkg::out_item_t          out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [canrxaf_pkg::PADDR_W-1:0] paddr,
  input  logic [canrxaf_pkg::PDATA_W-1:0] pwdata,
  output logic [canrxaf_pkg::PDATA_W-1:0] prdata,
  output logic                            pready
);
  import canrxaf_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      normal_mode_q;
  logic      reg_sel;
  logic      cfg_wr;

  // Register file: one control bit, written in the APB access phase.
  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && (reg_sel == REG_NORMAL_MODE);

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_NORMAL_MODE) begin
      prdata[0] = normal_mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      normal_mode_q <= pwdata[0];
    end
  end

  // Sequencer: accept a beat, then program one entry or scan the bank.
  canrxaf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .item_kind_i   (in_item_i.kind),
    .normal_mode_i (normal_mode_q),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o)
  );

  // Entry store, first-match compare and result registers.
  canrxaf_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hw/rtl/canrxaf_chk.sv =====
// Port-level checker for the acceptance filter, bound to the top level.
`include "can_rx_acceptance_filter_macros.svh"

module canrxaf_chk (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input canrxaf_pkg::out_item_t out_item_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i
);
  import canrxaf_pkg::*;

  `CRAF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "out beat dropped while stalled")
  `CRAF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_item_o), "out beat changed while stalled")
  `CRAF_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "second beat taken while one is in work")
  `CRAF_ASSERT_SAME(a_deliver_needs_match, clk_i, rst_ni, out_valid_o && out_item_o.delivered, out_item_o.matched, "delivered without a match")
  `CRAF_ASSERT_SAME(a_match_not_rejected, clk_i, rst_ni, out_valid_o && out_item_o.rejected, !out_item_o.matched && (out_item_o.hit_entry == '0), "rejected program beat shows a match")

endmodule

bind can_rx_acceptance_filter canrxaf_chk u_canrxaf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_item_o  (out_item_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

// ===== tb/sv/tb_can_rx_acceptance_filter.sv =====
// Self-checking testbench for the CAN receive acceptance filter bank.
module tb_can_rx_acceptance_filter;
  import canrxaf_pkg::*;

  localparam int ENTRIES = 16;
  localparam int ITEMS_PER_PHASE = 200;
  localparam logic [PADDR_W-1:0] NORMAL_MODE_ADDR = PADDR_W'({REG_NORMAL_MODE, 2'b00});

  // One directed step: the mode it runs in, the beat, and a typed-in
  // expectation where the answer is plain (otherwise the lookup decides).
  typedef struct packed {
    logic      mode;
    in_item_t  beat;
    logic      typed;
    out_item_t want;
  } directed_step_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Typed-in expectation travels beside the beat, driven the same way.
  logic      beat_typed = 1'b0;
  out_item_t beat_want = '0;

  // Shadow copy of the filter bank and the mode register.
  logic [KEY_W-1:0] shadow_ident [ENTRIES];
  logic [KEY_W-1:0] shadow_mask  [ENTRIES];
  logic             shadow_valid [ENTRIES];
  logic             shadow_normal;

  out_item_t        expected_verdicts [$];
  directed_step_t   directed_steps [$];
  int unsigned      mismatches = 0;

  // Idle switches, set per phase so some phases run back to back.
  logic src_idle_en  = 1'b1;
  logic sink_idle_en = 1'b1;
  int   sink_hold = 0;

  can_rx_acceptance_filter #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  // Mostly short idles, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Clear the shadow bank to its reset contents.
  function automatic void shadow_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_ident[i] = IDENT_RESET;
      shadow_mask[i]  = MASK_RESET;
      shadow_valid[i] = 1'b0;
    end
    shadow_normal = 1'b0;
  endfunction

  // Apply one beat to the shadow bank and return the verdict it earns.
  // A program beat with a receiver stores the ID with RTR on top and the RTR
  // bit forced into the mask, else is rejected; a frame in normal mode scans
  // from entry 0 and stops at the first hit, even on an unprogrammed entry.
  function automatic out_item_t filter_lookup(in_item_t b);
    out_item_t        r;
    logic [KEY_W-1:0] key;
    logic             found;
    r = '0;
    found = 1'b0;
    if (b.kind == KIND_PROGRAM) begin
      if (b.has_receiver && int'(b.entry_index) < ENTRIES) begin
        shadow_ident[b.entry_index] = {b.filter_rtr, b.filter_id};
        shadow_mask[b.entry_index]  = {1'b1, b.filter_mask};
        shadow_valid[b.entry_index] = 1'b1;
      end else begin
        r.rejected = 1'b1;
      end
    end else if (shadow_normal) begin
      key = {b.frame_rtr, b.frame_id};
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && ((key ^ shadow_ident[i]) & shadow_mask[i]) == '0) begin
          found       = 1'b1;
          r.matched   = 1'b1;
          r.delivered = shadow_valid[i];
          r.hit_entry = i[HIT_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t program_beat(logic [3:0] idx, logic [ID_W-1:0] id,
                                            logic [ID_W-1:0] msk, logic rtr, logic recv);
    in_item_t b;
    b = '1;
    b.kind         = KIND_PROGRAM;
    b.entry_index  = idx;
    b.filter_id    = id;
    b.filter_mask  = msk;
    b.filter_rtr   = rtr;
    b.has_receiver = recv;
    return b;
  endfunction

  function automatic in_item_t frame_beat(logic [ID_W-1:0] id, logic rtr);
    in_item_t b;
    b = '1;
    b.kind      = KIND_FRAME;
    b.frame_id  = id;
    b.frame_rtr = rtr;
    return b;
  endfunction

  function automatic out_item_t verdict(logic m, logic d, logic [HIT_W-1:0] h, logic rej);
    out_item_t r;
    r.matched   = m;
    r.delivered = d;
    r.hit_entry = h;
    r.rejected  = rej;
    return r;
  endfunction

  // Random beat. Half the frames are aimed at a stored entry (key built from its
  // identifier with only don't-care bits flipped) so the scan goes deep;
  // the rest hit key zero or land anywhere.
  function automatic in_item_t random_beat();
    in_item_t         b;
    logic [63:0]      raw;
    logic [KEY_W-1:0] key;
    int               e;
    int               r;
    raw = {$urandom, $urandom};
    b = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 99) < 35) begin
      b.kind = KIND_PROGRAM;
      b.has_receiver = ($urandom_range(0, 99) < 85);
      case ($urandom_range(0, 3))
        0: b.filter_mask = '1;
        1: b.filter_mask = '0;
        2: b.filter_mask = ID_W'($urandom & $urandom);
        default: ;
      endcase
    end else begin
      b.kind = KIND_FRAME;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        e = $urandom_range(0, ENTRIES - 1);
        key = shadow_ident[e] ^ (KEY_W'($urandom) & ~shadow_mask[e]);
        {b.frame_rtr, b.frame_id} = key;
      end else if (r < 62) begin
        b.frame_rtr = 1'b0;
        b.frame_id  = '0;
      end
    end
    return b;
  endfunction

  // Present one beat after an optional idle and hold it until accepted.
  task automatic send_beat(in_item_t b, logic typed, out_item_t want);
    int gap;
    gap = src_idle_en ? idle_cycles() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= b;
    beat_typed <= typed;
    beat_want  <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait for every outstanding verdict to come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, then access until pready, then the bus
  // idles so the next transfer starts from a released bus.
  task automatic apb_xfer(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write normal_mode with the bank idle, then read it back.
  task automatic set_mode(logic mode);
    logic [PDATA_W-1:0] rd;
    drain_results();
    apb_xfer(1'b1, NORMAL_MODE_ADDR, PDATA_W'(mode), rd);
    shadow_normal = mode;
    apb_xfer(1'b0, NORMAL_MODE_ADDR, '0, rd);
    if (rd !== PDATA_W'(mode)) begin
      $display("%0t: normal_mode readback expected %0h actual %0h", $time, mode, rd);
      mismatches++;
    end
  endtask

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sink: random backpressure, with phases of none at all.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (sink_hold > 0) begin
      out_ready_i <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (sink_idle_en) sink_hold = idle_cycles();
    end
  end

  // Monitor: predict on every accepted input beat, compare every output beat
  // against the oldest expectation.
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = filter_lookup(in_item_i);
        if (beat_typed) want = beat_want;
        expected_verdicts.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result expected none actual %p", $time, out_item_o);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("matched", 4'(want.matched), 4'(out_item_o.matched));
          check_field("delivered", 4'(want.delivered), 4'(out_item_o.delivered));
          check_field("hit_entry", 4'(want.hit_entry), 4'(out_item_o.hit_entry));
          check_field("rejected", 4'(want.rejected), 4'(out_item_o.rejected));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    directed_step_t step;
    logic           phase_mode [8];

    phase_mode = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    shadow_reset();

    // Ignored frames and idle-mode programming.
    directed_steps.push_back({1'b0, frame_beat(11'h000, 1'b0), 1'b1, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b0, frame_beat(11'h7FF, 1'b1), 1'b1, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b0, program_beat(4'd0, 11'h123, 11'h7FF, 1'b0, 1'b1), 1'b1,
                              verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b0, program_beat(4'd5, 11'h7FF, 11'h7FF, 1'b1, 1'b0), 1'b1,
                              verdict(0, 0, 0, 1)});
    // Key zero stops on the first unprogrammed entry, undelivered.
    directed_steps.push_back({1'b1, frame_beat(11'h000, 1'b0), 1'b1, verdict(1, 0, 1, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h123, 1'b0), 1'b1, verdict(1, 1, 0, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h123, 1'b1), 1'b0, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, program_beat(4'd15, 11'h7FF, 11'h000, 1'b1, 1'b1), 1'b1,
                              verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h555, 1'b1), 1'b0, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, program_beat(4'd1, 11'h000, 11'h000, 1'b0, 1'b1), 1'b1,
                              verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h7FF, 1'b0), 1'b0, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, program_beat(4'd2, 11'h000, 11'h000, 1'b0, 1'b0), 1'b1,
                              verdict(0, 0, 0, 1)});
    directed_steps.push_back({1'b1, program_beat(4'd14, 11'h7FF, 11'h7FF, 1'b0, 1'b1), 1'b1,
                              verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h7FF, 1'b1), 1'b0, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, program_beat(4'd0, 11'h2AA, 11'h555, 1'b1, 1'b1), 1'b1,
                              verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h2AA, 1'b1), 1'b0, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h7FF, 1'b1), 1'b0, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b1, frame_beat(11'h000, 1'b1), 1'b0, verdict(0, 0, 0, 0)});
    // Back out of normal mode: frames drop even where entries would hit.
    directed_steps.push_back({1'b0, frame_beat(11'h2AA, 1'b1), 1'b1, verdict(0, 0, 0, 0)});
    directed_steps.push_back({1'b0, program_beat(4'd3, 11'h555, 11'h2AA, 1'b0, 1'b1), 1'b1,
                              verdict(0, 0, 0, 0)});

    // Reset once, then write the mode register from the idle state.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(1'b0);

    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      if (step.mode != shadow_normal) set_mode(step.mode);
      send_beat(step.beat, step.typed, step.want);
    end

    // Random phases; each one rewrites the mode and picks its idling.
    for (int p = 0; p < 8; p++) begin
      set_mode(phase_mode[p]);
      src_idle_en  = (p % 3 != 2);
      sink_idle_en = (p % 4 != 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_beat(random_beat(), 1'b0, '0);
      end
    end

    // Let stray results show up before the verdict.
    drain_results();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/canrxaf_pkg.sv
hw/rtl/canrxaf_dp.sv
hw/rtl/canrxaf_ctrl.sv
hw/rtl/can_rx_acceptance_filter.sv
hw/rtl/canrxaf_chk.sv
tb/sv/tb_can_rx_acceptance_filter.sv
